@@ sv/flow_matrix_transitive_closure_unit_assert.svh @@
// Assertion macros for the flow matrix closure unit.
`ifndef FLOW_MATRIX_TRANSITIVE_CLOSURE_UNIT_ASSERT_SVH
`define FLOW_MATRIX_TRANSITIVE_CLOSURE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define FMTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define FMTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fmtc_pkg.sv @@
// Shared types and codes of the flow matrix closure unit.
`default_nettype none

package fmtc_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_QUERY = 2'd3
  } fmtc_mode_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_ADD,
    CELL_STEP
  } fmtc_cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_CLOSE
  } fmtc_state_e;

  typedef enum logic {
    CFG_LEVEL_COUNT   = 1'b0,
    CFG_IS_TRANSITIVE = 1'b1
  } fmtc_cfg_e;

  localparam int unsigned LevelW    = 4;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;
  localparam logic [4:0]  LevelCountRst = 5'd16;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    fmtc_cell_op_e     op;
    logic [LevelW-1:0] src;
    logic [LevelW-1:0] dst;
  } fmtc_ctrl_t;

endpackage

`default_nettype wire

@@ sv/flow_matrix_transitive_closure_unit.sv @@
// Top level of the flow matrix closure unit: sequencer and ring of row cells.
//
//  channel   | dir | fields (low bit first)              | handshake
//  ----------+-----+-------------------------------------+---------------------
//  s_axis    | in  | mode[1:0] src[5:2] dst[9:6] pad     | tvalid & tready
//  m_axis    | out | allowed[0] status[1] pad            | tvalid & tready
//  cfg       | in  | idx 0 level_count, 1 is_transitive  | cfg_we_i, no wait
//
// Clear, add and query words do not hold tready low. A closure word, with
// is_transitive set, holds tready low while the rows rotate
// once round the ring of cells, one Warshall pivot per cycle, the pivot being
// whatever row sits in cell 0. Its result word is issued at once.
// A single output register; a new word is taken in the cycle the waiting
// result leaves, or when no result waits.
// Reset loads the identity matrix, level_count 16, is_transitive 0.
`default_nettype none

module flow_matrix_transitive_closure_unit #(
  parameter int unsigned MAX_LEVELS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // mode[1:0], src_level[5:2], dst_level[9:6], zeros above
  input  wire logic [fmtc_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // allowed[0], status[1], zeros above
  output logic [fmtc_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [fmtc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fmtc_pkg::*;

  `include "flow_matrix_transitive_closure_unit_assert.svh"

  localparam int unsigned IW  = $clog2(MAX_LEVELS);
  localparam int unsigned CW  = $clog2(MAX_LEVELS + 1);
  localparam int unsigned NW  = (CW > CfgDataW) ? CW : CfgDataW;

  // configuration
  logic [CfgDataW-1:0] level_count_q;
  logic                is_transitive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q   <= LevelCountRst;
      is_transitive_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (fmtc_cfg_e'(cfg_idx_i))
        CFG_LEVEL_COUNT:   level_count_q   <= cfg_data_i;
        CFG_IS_TRANSITIVE: is_transitive_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // count above the matrix size clamps to the matrix size
  logic [NW-1:0] n_eff;
  assign n_eff = (NW'(level_count_q) > NW'(MAX_LEVELS)) ? NW'(MAX_LEVELS)
                                                        : NW'(level_count_q);

  // input word
  fmtc_mode_e        in_mode;
  logic [LevelW-1:0] in_src, in_dst;
  logic              in_acc;
  logic              in_range;

  assign in_mode  = fmtc_mode_e'(s_axis_tdata_i[ModeW-1:0]);
  assign in_src   = s_axis_tdata_i[ModeW +: LevelW];
  assign in_dst   = s_axis_tdata_i[ModeW+LevelW +: LevelW];
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign in_range = (NW'(in_src) < n_eff) && (NW'(in_dst) < n_eff);

  // sequencer
  fmtc_state_e state_q, state_d;
  logic [IW-1:0] step_q, step_d;
  logic          step_last;
  logic          out_valid_q;
  fmtc_ctrl_t    ctrl;

  assign step_last = (step_q == IW'(MAX_LEVELS - 1));

  // ready only when idle and the output register is free or emptying
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_CLOSE) && is_transitive_q) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (step_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op         = CELL_HOLD;
    ctrl.src        = in_src;
    ctrl.dst        = in_dst;
    step_d          = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_CLEAR: ctrl.op = CELL_CLEAR;
            MODE_ADD:   ctrl.op = in_range ? CELL_ADD : CELL_HOLD;
            default:    ctrl.op = CELL_HOLD;
          endcase
        end
      end
      ST_CLOSE: begin
        ctrl.op = CELL_STEP;
        step_d  = step_q + IW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // ring of cells
  logic [MAX_LEVELS-1:0][MAX_LEVELS-1:0] rows;
  logic [MAX_LEVELS-1:0][MAX_LEVELS-1:0] upd_rows;
  logic [MAX_LEVELS-1:0][IW-1:0]         tags;
  logic [MAX_LEVELS-1:0]                 hits;
  logic [MAX_LEVELS-1:0]                 col_mask;
  logic [MAX_LEVELS-1:0]                 through;

  always_comb begin
    for (int j = 0; j < MAX_LEVELS; j++) begin
      col_mask[j] = (j < int'(n_eff));
    end
  end

  // pivot is the row now in cell 0; pivots beyond the count do nothing
  assign through = (NW'(step_q) < n_eff) ? (rows[0] & col_mask) : '0;

  for (genvar c = 0; c < MAX_LEVELS; c++) begin : g_cell
    fmtc_cell #(
      .MAX_LEVELS (MAX_LEVELS),
      .INDEX      (c),
      .IW         (IW),
      .NW         (NW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .step_i    (step_q),
      .n_eff_i   (n_eff),
      .through_i (through),
      .nb_row_i  (upd_rows[(c + 1) % MAX_LEVELS]),
      .nb_tag_i  (tags[(c + 1) % MAX_LEVELS]),
      .row_o     (rows[c]),
      .tag_o     (tags[c]),
      .upd_row_o (upd_rows[c]),
      .hit_o     (hits[c])
    );
  end

  // output register
  logic out_allowed_q, out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_status_q  <= ((in_mode == MODE_ADD) || (in_mode == MODE_QUERY)) && !in_range;
      out_allowed_q <= (in_mode == MODE_QUERY) && in_range && (|hits);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-2){1'b0}}, out_status_q, out_allowed_q};

  // checks
  `FMTC_ASSERT_SAME(a_busy_no_ready, state_q == ST_CLOSE, !s_axis_tready_o, "ready during closure")
  `FMTC_ASSERT_NEXT(a_close_start, in_acc && (in_mode == MODE_CLOSE) && is_transitive_q,
                    (state_q == ST_CLOSE) && (step_q == '0), "closure did not start")
  `FMTC_ASSERT_NEXT(a_close_end, (state_q == ST_CLOSE) && step_last, state_q == ST_IDLE,
                    "closure overran")
  `FMTC_ASSERT_SAME(a_rows_home, state_q == ST_IDLE, tags[0] == '0, "rows not back home")

endmodule

`default_nettype wire

@@ sv/fmtc_cell.sv @@
// One matrix row cell: holds a row and its tag, passes it on during closure.
`default_nettype none

module fmtc_cell #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned INDEX      = 0,
  parameter int unsigned IW         = 4,
  parameter int unsigned NW         = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire fmtc_pkg::fmtc_ctrl_t   ctrl_i,
  input  wire logic [IW-1:0]          step_i,
  input  wire logic [NW-1:0]          n_eff_i,
  input  wire logic [MAX_LEVELS-1:0]  through_i,
  input  wire logic [MAX_LEVELS-1:0]  nb_row_i,
  input  wire logic [IW-1:0]          nb_tag_i,
  output logic [MAX_LEVELS-1:0]       row_o,
  output logic [IW-1:0]               tag_o,
  output logic [MAX_LEVELS-1:0]       upd_row_o,
  output logic                        hit_o
);
  import fmtc_pkg::*;

  logic [MAX_LEVELS-1:0] row_q, row_d;
  logic [IW-1:0]         tag_q, tag_d;
  logic [MAX_LEVELS-1:0] dst_mask;
  logic [MAX_LEVELS-1:0] upd_row;
  logic                  src_hit;

  always_comb begin
    for (int j = 0; j < MAX_LEVELS; j++) begin
      dst_mask[j] = (int'(ctrl_i.dst) == j);
    end
  end

  assign src_hit = (int'(ctrl_i.src) == INDEX);

  // Warshall step: a row in scope that reaches the pivot ORs in the pivot's row
  always_comb begin
    upd_row = row_q;
    if ((NW'(tag_q) < n_eff_i) && row_q[step_i]) begin
      upd_row = row_q | through_i;
    end
  end

  always_comb begin
    row_d = row_q;
    tag_d = tag_q;
    case (ctrl_i.op)
      CELL_CLEAR: begin
        row_d = MAX_LEVELS'(1) << INDEX;
        tag_d = IW'(INDEX);
      end
      CELL_ADD: begin
        if (src_hit) begin
          row_d = row_q | dst_mask;
        end
      end
      CELL_STEP: begin
        row_d = nb_row_i;
        tag_d = nb_tag_i;
      end
      default: begin
        row_d = row_q;
        tag_d = tag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= MAX_LEVELS'(1) << INDEX;
      tag_q <= IW'(INDEX);
    end else begin
      row_q <= row_d;
      tag_q <= tag_d;
    end
  end

  assign row_o     = row_q;
  assign tag_o     = tag_q;
  assign upd_row_o = upd_row;
  assign hit_o     = src_hit & |(row_q & dst_mask);

endmodule

`default_nettype wire

@@ tb/tb_flow_matrix_transitive_closure_unit.sv @@
// Self-checking testbench for the flow matrix transitive closure unit.
`default_nettype none

module tb_flow_matrix_transitive_closure_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fmtc_pkg::*;

  localparam int unsigned Levels = 16;
  // closure rotates the rows once round the ring: allow that plus some slack
  localparam int unsigned SettleCycles = Levels + 8;

  // One command word as the sender sees it
  typedef struct packed {
    fmtc_mode_e        mode;
    logic [LevelW-1:0] src;
    logic [LevelW-1:0] dst;
  } flow_cmd_t;

  // One result word: the two fields of m_axis_tdata
  typedef struct packed {
    logic status;
    logic allowed;
  } flow_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [InDataW-1:0]   s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OutDataW-1:0]  m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  fmtc_cfg_e            cfg_idx = CFG_LEVEL_COUNT;
  logic [CfgDataW-1:0]  cfg_data = '0;

  flow_matrix_transitive_closure_unit #(
    .MAX_LEVELS (Levels)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predicted state: allowed-flow rows and the two register copies
  // ---------------------------------------------------------------------------
  logic [Levels-1:0]   policy_rows [Levels];
  logic [CfgDataW-1:0] level_cnt_q;
  logic                transitive_q;

  flow_cmd_t    pending_q [$];   // words waiting for the driver
  flow_result_t verdict_q [$];   // expected result words, oldest first

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned n_queued    = 0;
  int unsigned n_words_in  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_closures  = 0;
  int unsigned n_out_range = 0;
  int unsigned err_count   = 0;
  logic        in_fire     = 1'b0;

  function automatic void load_identity_rows();
    for (int r = 0; r < Levels; r++) begin
      policy_rows[r] = '0;
      policy_rows[r][r] = 1'b1;
    end
  endfunction

  // level_count above the matrix size saturates; zero leaves no level in range
  function automatic int unsigned active_level_cnt();
    return (level_cnt_q > Levels) ? Levels : int'(level_cnt_q);
  endfunction

  // Works out the result word of one command and updates the predicted matrix
  function automatic flow_result_t predict_flow(flow_cmd_t c);
    flow_result_t      r;
    int unsigned       n;
    logic [Levels-1:0] cols;
    logic [Levels-1:0] through;
    r = '0;
    n = active_level_cnt();
    case (c.mode)
      MODE_CLEAR: begin
        load_identity_rows();   // all rows, whatever the level count
      end
      MODE_CLOSE: begin
        n_closures++;
        if (transitive_q) begin
          cols = '0;
          for (int i = 0; i < n; i++) cols[i] = 1'b1;
          // Warshall: pivot level outermost
          for (int via = 0; via < n; via++) begin
            through = policy_rows[via] & cols;
            for (int row = 0; row < n; row++) begin
              if (policy_rows[row][via]) policy_rows[row] = policy_rows[row] | through;
            end
          end
        end
      end
      default: begin
        if (c.src >= n || c.dst >= n) begin
          r.status = 1'b1;
          n_out_range++;
        end else if (c.mode == MODE_ADD) begin
          policy_rows[c.src][c.dst] = 1'b1;
        end else begin
          r.allowed = policy_rows[c.src][c.dst];
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("tb: MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes the next word from pending_q at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || in_fire) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          flow_cmd_t c;
          c = pending_q.pop_front();
          // mode[1:0], src[5:2], dst[9:6], zero padding above
          s_tdata  <= {{(InDataW - ModeW - 2*LevelW){1'b0}}, c.dst, c.src, c.mode};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted command word, checks every result word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    flow_cmd_t    cmd;
    flow_result_t want;
    if (rst_ni) begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        cmd.mode = fmtc_mode_e'(s_tdata[ModeW-1:0]);
        cmd.src  = s_tdata[ModeW +: LevelW];
        cmd.dst  = s_tdata[ModeW+LevelW +: LevelW];
        verdict_q.push_back(predict_flow(cmd));
        n_words_in++;
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result word 0x%0h with nothing expected", m_tdata));
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (m_tdata[0] !== want.allowed)
            report_mismatch($sformatf("word %0d allowed %b, want %b",
                                      n_checked, m_tdata[0], want.allowed));
          if (m_tdata[1] !== want.status)
            report_mismatch($sformatf("word %0d status %b, want %b",
                                      n_checked, m_tdata[1], want.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input fmtc_mode_e mode, input logic [3:0] src,
                          input logic [3:0] dst);
    flow_cmd_t c;
    c.mode = mode;
    c.src  = src;
    c.dst  = dst;
    pending_q.push_back(c);
    n_queued++;
  endtask

  // Mostly a level in range; now and then any 4-bit value
  function automatic logic [3:0] pick_level(int unsigned n);
    if (n == 0 || $urandom_range(99) < 8) return 4'($urandom_range(15));
    return 4'($urandom_range(n - 1));
  endfunction

  // Waits until the driver is empty and every result word has come back,
  // then lets a closure still rotating in the ring run out
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #0.5;
    end while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input fmtc_cfg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_LEVEL_COUNT) level_cnt_q = val;
    else transitive_q = val[0];
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Random traffic: mostly clear / add / close / query runs, the rest noise
  task automatic fill_random(input int unsigned count);
    int unsigned target;
    int unsigned n;
    int unsigned k;
    target = n_queued + count;
    n = active_level_cnt();
    while (n_queued < target) begin
      if ($urandom_range(99) < 72) begin
        if ($urandom_range(99) < 70)
          push_cmd(MODE_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
        k = $urandom_range(1, 12);
        repeat (k) push_cmd(MODE_ADD, pick_level(n), pick_level(n));
        if ($urandom_range(99) < 85)
          push_cmd(MODE_CLOSE, 4'($urandom_range(15)), 4'($urandom_range(15)));
        k = $urandom_range(1, 10);
        repeat (k) push_cmd(MODE_QUERY, pick_level(n), pick_level(n));
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) push_cmd(fmtc_mode_e'($urandom_range(3)),
                            4'($urandom_range(15)), 4'($urandom_range(15)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [CfgDataW-1:0] phase_levels [12] = '{5'd16, 5'd1, 5'd2, 5'd16, 5'd8, 5'd31,
                                            5'd16, 5'd3, 5'd0, 5'd16, 5'd12, 5'd5};
  logic                phase_trans  [12] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                                            1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  initial begin
    level_cnt_q  = LevelCountRst;
    transitive_q = 1'b0;
    load_identity_rows();
    tx_idle_pct = 35;
    rx_idle_pct = 81;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset state: identity, 16 levels, closure disabled
    push_cmd(MODE_QUERY, 4'd0, 4'd0);
    push_cmd(MODE_QUERY, 4'd15, 4'd15);
    push_cmd(MODE_QUERY, 4'd0, 4'd15);
    push_cmd(MODE_ADD, 4'd0, 4'd5);
    push_cmd(MODE_ADD, 4'd5, 4'd15);
    push_cmd(MODE_CLOSE, 4'd15, 4'd0);      // disabled: no change
    push_cmd(MODE_QUERY, 4'd0, 4'd15);
    wait_drained();

    // Closure enabled: the 0 -> 5 -> 15 chain becomes a direct flow
    write_reg(CFG_IS_TRANSITIVE, 5'd1);
    push_cmd(MODE_CLOSE, 4'd0, 4'd0);
    push_cmd(MODE_QUERY, 4'd0, 4'd15);
    push_cmd(MODE_QUERY, 4'd15, 4'd0);
    wait_drained();

    // Four levels: level 4 and up out of range, matrix kept as it was
    write_reg(CFG_LEVEL_COUNT, 5'd4);
    push_cmd(MODE_ADD, 4'd4, 4'd0);
    push_cmd(MODE_QUERY, 4'd0, 4'd4);
    push_cmd(MODE_ADD, 4'd3, 4'd2);
    push_cmd(MODE_ADD, 4'd2, 4'd1);
    push_cmd(MODE_CLOSE, 4'd9, 4'd6);
    push_cmd(MODE_QUERY, 4'd3, 4'd1);
    wait_drained();

    // No level in range at all
    write_reg(CFG_LEVEL_COUNT, 5'd0);
    push_cmd(MODE_QUERY, 4'd0, 4'd0);
    push_cmd(MODE_ADD, 4'd0, 4'd0);
    push_cmd(MODE_CLOSE, 4'd0, 4'd0);
    push_cmd(MODE_CLEAR, 4'd15, 4'd15);
    wait_drained();

    // Count above the matrix size saturates to sixteen
    write_reg(CFG_LEVEL_COUNT, 5'd31);
    push_cmd(MODE_QUERY, 4'd15, 4'd15);
    push_cmd(MODE_QUERY, 4'd0, 4'd15);      // cleared by the previous phase
    push_cmd(MODE_ADD, 4'd14, 4'd15);
    push_cmd(MODE_QUERY, 4'd14, 4'd15);
    wait_drained();

    // Random phases; idling pattern changes every four phases
    for (int p = 0; p < 12; p++) begin
      case (p / 4)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_reg(CFG_LEVEL_COUNT, phase_levels[p]);
      write_reg(CFG_IS_TRANSITIVE, {4'd0, phase_trans[p]});
      fill_random(145);
      wait_drained();
    end

    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", verdict_q.size()));

    $display("tb: %0d command words, %0d results checked, %0d closures, %0d out of range",
             n_words_in, n_checked, n_closures, n_out_range);
    $display("tb: level counts 0 to 31 with closure on and off, three idling patterns");
    if (err_count == 0) begin
      $display("tb_flow_matrix_transitive_closure_unit: done, clean");
    end else begin
      $display("tb_flow_matrix_transitive_closure_unit: done, errors");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: watchdog expired, %0d words in, %0d checked", n_words_in, n_checked);
    $display("tb_flow_matrix_transitive_closure_unit: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/fmtc_pkg.sv
sv/fmtc_cell.sv
sv/flow_matrix_transitive_closure_unit.sv
tb/tb_flow_matrix_transitive_closure_unit.sv
